@@ sv/vtdi_pkg.sv @@
// vtdi_pkg: shared constants, types and helpers of the vertex triple dedup indexer
// used by vtdi_scan_ctrl and vertex_triple_dedup_indexer_top; no dependencies
package vtdi_pkg;

	localparam int unsigned MAX_UNIQUE    = 1024;
	localparam int unsigned INDEX_BITS    = 20;
	localparam int unsigned IN_FIELD_BITS = 20;
	localparam int unsigned VIDX_BITS     = 10;
	localparam int unsigned ADDR_BITS     = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
	localparam int unsigned COUNT_BITS    = $clog2(MAX_UNIQUE + 1);
	localparam int unsigned ENTRY_BITS    = 3 * INDEX_BITS;

	localparam int unsigned S_TDATA_BITS  = ((3 * IN_FIELD_BITS + 7) / 8) * 8;
	localparam int unsigned S_TUSER_BITS  = 1;
	localparam int unsigned M_TDATA_BITS  = ((VIDX_BITS + 7) / 8) * 8;
	localparam int unsigned M_TUSER_BITS  = 2;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_BITS-1:0]  rd_addr;
		logic                  wr_en;
		logic [ADDR_BITS-1:0]  wr_addr;
		logic [ENTRY_BITS-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic                 valid;
		logic [ADDR_BITS-1:0] idx;
		logic                 is_new;
		logic                 overflow;
	} res_t;

	// keep the low INDEX_BITS bits of an input index field
	function automatic logic [INDEX_BITS-1:0] to_index(input logic [IN_FIELD_BITS-1:0] f);
		logic [IN_FIELD_BITS+INDEX_BITS-1:0] ext;
		ext = {{INDEX_BITS{1'b0}}, f};
		return ext[INDEX_BITS-1:0];
	endfunction

	// low VIDX_BITS bits of a table address
	function automatic logic [VIDX_BITS-1:0] to_vidx(input logic [ADDR_BITS-1:0] a);
		logic [ADDR_BITS+VIDX_BITS-1:0] ext;
		ext = {{VIDX_BITS{1'b0}}, a};
		return ext[VIDX_BITS-1:0];
	endfunction

endpackage

@@ sv/vtdi_table_ram.sv @@
// vtdi_table_ram: generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies
module vtdi_table_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 60,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ sv/vtdi_scan_ctrl.sv @@
// vtdi_scan_ctrl: entry count, scan sequencer and insert logic around the triple table
// depends on vtdi_pkg; drives vtdi_table_ram through a mem_req_t bundle
module vtdi_scan_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  vtdi_pkg::op_t                  in_op,
	input  logic [vtdi_pkg::ENTRY_BITS-1:0] in_key,
	output vtdi_pkg::mem_req_t             mem_req,
	input  logic [vtdi_pkg::ENTRY_BITS-1:0] rd_data,
	output vtdi_pkg::res_t                 res,
	input  logic                           res_take
);

	vtdi_pkg::state_t state_q, state_d;

	logic [vtdi_pkg::COUNT_BITS-1:0] count_q;
	logic [vtdi_pkg::COUNT_BITS-1:0] ptr_q;
	logic [vtdi_pkg::ENTRY_BITS-1:0] key_q;
	logic                            rvalid_s1;
	logic [vtdi_pkg::ADDR_BITS-1:0]  raddr_s1;
	logic [vtdi_pkg::ADDR_BITS-1:0]  res_idx_q;
	logic                            res_new_q;
	logic                            res_ovf_q;

	logic accept, hit, last, full, issue;

	assign accept = in_valid && in_ready;
	assign hit    = rvalid_s1 && (rd_data == key_q);
	assign last   = rvalid_s1 && (vtdi_pkg::COUNT_BITS'(raddr_s1) + 1'b1 == count_q);
	assign full   = (count_q == vtdi_pkg::COUNT_BITS'(vtdi_pkg::MAX_UNIQUE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtdi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		issue            = 1'b0;
		mem_req.rd_en    = 1'b0;
		mem_req.rd_addr  = ptr_q[vtdi_pkg::ADDR_BITS-1:0];
		mem_req.wr_en    = 1'b0;
		mem_req.wr_addr  = count_q[vtdi_pkg::ADDR_BITS-1:0];
		mem_req.wr_data  = key_q;
		res.valid        = 1'b0;
		res.idx          = res_idx_q;
		res.is_new       = res_new_q;
		res.overflow     = res_ovf_q;
		unique case (state_q)
			vtdi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == vtdi_pkg::OP_CLEAR) begin
						state_d = vtdi_pkg::ST_RESULT;
					end else if (count_q == '0) begin
						state_d = vtdi_pkg::ST_MISS;
					end else begin
						state_d = vtdi_pkg::ST_SCAN;
					end
				end
			end
			vtdi_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = vtdi_pkg::ST_RESULT;
				end else if (last) begin
					state_d = vtdi_pkg::ST_MISS;
				end else if (ptr_q < count_q) begin
					issue         = 1'b1;
					mem_req.rd_en = 1'b1;
				end
			end
			vtdi_pkg::ST_MISS: begin
				mem_req.wr_en = !full;
				state_d       = vtdi_pkg::ST_RESULT;
			end
			vtdi_pkg::ST_RESULT: begin
				res.valid = 1'b1;
				if (res_take) begin
					state_d = vtdi_pkg::ST_IDLE;
				end
			end
			default: state_d = vtdi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			if (accept && in_op == vtdi_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (mem_req.wr_en) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		raddr_s1 <= ptr_q[vtdi_pkg::ADDR_BITS-1:0];
		if (accept) begin
			key_q     <= in_key;
			ptr_q     <= '0;
			res_idx_q <= '0;
			res_new_q <= 1'b0;
			res_ovf_q <= 1'b0;
		end else if (issue) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (state_q == vtdi_pkg::ST_SCAN && hit) begin
			res_idx_q <= raddr_s1;
		end
		if (state_q == vtdi_pkg::ST_MISS) begin
			res_idx_q <= full ? '0 : count_q[vtdi_pkg::ADDR_BITS-1:0];
			res_new_q <= !full;
			res_ovf_q <= full;
		end
	end

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.wr_en))
		else $error("table read and write in the same cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vtdi_pkg::COUNT_BITS'(vtdi_pkg::MAX_UNIQUE))
		else $error("entry count above table depth");

	a_read_valid_entry: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en |-> (ptr_q < count_q))
		else $error("read of an entry beyond the count");

	a_write_grows_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not advance the count");

	a_new_excl_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.is_new && res.overflow))
		else $error("result both new and overflow");

endmodule

@@ sv/vertex_triple_dedup_indexer_top.sv @@
// vertex_triple_dedup_indexer_top: stream ports, key packing and output register
// depends on vtdi_pkg, vtdi_table_ram and vtdi_scan_ctrl
// flow: one item at a time; s_tready is high only in the idle state, so a new item is taken
// only after the result of the last has moved to the output register; a scan walks the
// single read port of the triple table one entry per cycle
// reset: arst_n clears the entry count and the control state; table contents are not cleared
module vertex_triple_dedup_indexer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: pos_index [19:0], tex_index [39:20], norm_index [59:40], zero pad
	input  logic [vtdi_pkg::S_TDATA_BITS-1:0] s_tdata,
	// s_tuser: op [0]
	input  logic [vtdi_pkg::S_TUSER_BITS-1:0] s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: vertex_index [9:0], zero pad
	output logic [vtdi_pkg::M_TDATA_BITS-1:0] m_tdata,
	// m_tuser: is_new [0], overflow [1]
	output logic [vtdi_pkg::M_TUSER_BITS-1:0] m_tuser
);

	localparam int unsigned FB = vtdi_pkg::IN_FIELD_BITS;

	vtdi_pkg::mem_req_t              mem_req;
	vtdi_pkg::res_t                  res;
	logic [vtdi_pkg::ENTRY_BITS-1:0] key;
	logic [vtdi_pkg::ENTRY_BITS-1:0] rd_data;
	vtdi_pkg::op_t                   op;
	logic                            res_take;

	logic                            m_tvalid_q;
	logic [vtdi_pkg::VIDX_BITS-1:0]  vidx_q;
	logic                            is_new_q;
	logic                            overflow_q;

	// stored key: norm in the top bits, pos in the low bits, each cut to the index width
	assign key = {vtdi_pkg::to_index(s_tdata[3*FB-1:2*FB]),
	              vtdi_pkg::to_index(s_tdata[2*FB-1:FB]),
	              vtdi_pkg::to_index(s_tdata[FB-1:0])};
	assign op  = vtdi_pkg::op_t'(s_tuser[0]);

	// result moves into the output register whenever the slot is empty or draining
	assign res_take = !m_tvalid_q || m_tready;

	vtdi_scan_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (op),
		.in_key   (key),
		.mem_req  (mem_req),
		.rd_data  (rd_data),
		.res      (res),
		.res_take (res_take)
	);

	vtdi_table_ram #(
		.DEPTH (vtdi_pkg::MAX_UNIQUE),
		.WIDTH (vtdi_pkg::ENTRY_BITS)
	) u_table (
		.clk     (clk),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_data),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data)
	);

	// output register, valid cleared under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res.valid) begin
			vidx_q     <= vtdi_pkg::to_vidx(res.idx);
			is_new_q   <= res.is_new;
			overflow_q <= res.overflow;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = vtdi_pkg::M_TDATA_BITS'(vidx_q);
	assign m_tuser  = {overflow_q, is_new_q};

endmodule
